[rtl/core/gapsc_pkg.sv]
// Shared types and constants for the gate array palette and sync control block.
package gapsc_pkg;

    localparam int PEN_COUNT = 17;
    localparam int PEN_W     = 5;
    localparam int COLOUR_W  = 5;
    localparam int MF_W      = 6;
    localparam int MODE_W    = 2;
    localparam int BCNT_W    = 3;
    localparam int OUT_W     = 25;

    localparam logic [PEN_W-1:0]  BORDER_PEN = 5'd16;
    localparam logic [BCNT_W-1:0] BCNT_SYNC_ON  = 3'd1;
    localparam logic [BCNT_W-1:0] BCNT_SYNC_OFF = 3'd5;
    localparam logic [BCNT_W-1:0] BCNT_MAX      = 3'd7;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_HSYNC = 2'd1;
    localparam logic [1:0] ACT_VSYNC = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    localparam logic [1:0] WR_PEN    = 2'b00;
    localparam logic [1:0] WR_COLOUR = 2'b01;
    localparam logic [1:0] WR_MF     = 2'b10;
    localparam logic [1:0] WR_NONE   = 2'b11;

    typedef struct packed {
        logic                we;
        logic                re;
        logic [PEN_W-1:0]    addr;
        logic [COLOUR_W-1:0] wdata;
    } gapsc_mem_req_t;

    typedef struct packed {
        logic              vblank;
        logic              hblank;
        logic              mon_sync;
        logic              irq;
        logic [MODE_W-1:0] line_mode;
        logic [MF_W-1:0]   mf;
        logic              colour_written;
        logic [PEN_W-1:0]  pen;
    } gapsc_status_t;

endpackage

[rtl/core/gapsc_pal_ram.sv]
// Palette memory: 17 entries, one port, write-first, registered read, valid bits for reset.
module gapsc_pal_ram
    import gapsc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  gapsc_mem_req_t      req,
    output logic [COLOUR_W-1:0] rd_data
);

    logic [COLOUR_W-1:0]  mem [PEN_COUNT];
    logic [PEN_COUNT-1:0] valid_reg;
    logic [COLOUR_W-1:0]  rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.we) begin
            valid_reg[req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.we) begin
            rd_data_reg <= req.wdata;
        end else if (req.re) begin
            rd_data_reg <= valid_reg[req.addr] ? mem[req.addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

`ifndef SYNTHESIS
    a_write_first: assert property (@(posedge aclk) disable iff (!aresetn)
        req.we |=> rd_data == $past(req.wdata))
        else $error("palette write not returned on read port");
`endif

endmodule

[rtl/core/gapsc_ctrl.sv]
// Event decode and control registers: pen select, multifunction, sync, blanking, irq.
module gapsc_ctrl
    import gapsc_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  logic [1:0]     action,
    input  logic [7:0]     data,
    input  logic           level,
    input  logic           timer_out,
    output gapsc_mem_req_t mem_req,
    output gapsc_status_t  status
);

    logic [PEN_W-1:0]  pen_reg,   pen_next;
    logic [MF_W-1:0]   mf_reg,    mf_next;
    logic [MODE_W-1:0] mode_reg,  mode_next;
    logic              irq_reg,   irq_next;
    logic              hs_reg,    hs_next;
    logic [BCNT_W-1:0] bcnt_reg,  bcnt_next;
    logic              mon_reg,   mon_next;
    logic              vs_reg,    vs_next;
    logic              cw_reg,    cw_next;

    always_comb begin
        pen_next  = pen_reg;
        mf_next   = mf_reg;
        mode_next = mode_reg;
        irq_next  = irq_reg;
        hs_next   = hs_reg;
        bcnt_next = bcnt_reg;
        mon_next  = mon_reg;
        vs_next   = vs_reg;
        cw_next   = 1'b0;
        unique case (action)
            ACT_WRITE: begin
                unique case (data[7:6])
                    WR_PEN: begin
                        pen_next = data[4] ? BORDER_PEN : {1'b0, data[3:0]};
                    end
                    WR_COLOUR: begin
                        cw_next = 1'b1;
                    end
                    WR_MF: begin
                        mf_next = data[5:0];
                        if (data[4]) begin
                            irq_next = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ACT_HSYNC: begin
                if (level) begin
                    hs_next   = 1'b1;
                    bcnt_next = '0;
                    mode_next = mf_reg[MODE_W-1:0];
                end else begin
                    hs_next  = 1'b0;
                    mon_next = 1'b0;
                end
                irq_next = timer_out;
            end
            ACT_VSYNC: begin
                if (level != vs_reg) begin
                    vs_next = level;
                    if (level) begin
                        irq_next = timer_out;
                    end
                end
            end
            default: begin
                if (hs_reg) begin
                    if (bcnt_reg == BCNT_SYNC_ON) begin
                        mon_next = 1'b1;
                    end else if (bcnt_reg == BCNT_SYNC_OFF) begin
                        mon_next = 1'b0;
                    end
                    if (bcnt_reg != BCNT_MAX) begin
                        bcnt_next = bcnt_reg + 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_reg  <= '0;
            mf_reg   <= '0;
            mode_reg <= '0;
            irq_reg  <= 1'b0;
            hs_reg   <= 1'b0;
            bcnt_reg <= '0;
            mon_reg  <= 1'b0;
            vs_reg   <= 1'b0;
            cw_reg   <= 1'b0;
        end else if (accept) begin
            pen_reg  <= pen_next;
            mf_reg   <= mf_next;
            mode_reg <= mode_next;
            irq_reg  <= irq_next;
            hs_reg   <= hs_next;
            bcnt_reg <= bcnt_next;
            mon_reg  <= mon_next;
            vs_reg   <= vs_next;
            cw_reg   <= cw_next;
        end
    end

    // colour write goes to the current pen; anything else reads the new pen
    assign mem_req.we    = accept && cw_next;
    assign mem_req.re    = accept && !cw_next;
    assign mem_req.addr  = cw_next ? pen_reg : pen_next;
    assign mem_req.wdata = data[COLOUR_W-1:0];

    assign status.vblank         = vs_reg;
    assign status.hblank         = hs_reg;
    assign status.mon_sync       = mon_reg;
    assign status.irq            = irq_reg;
    assign status.line_mode      = mode_reg;
    assign status.mf             = mf_reg;
    assign status.colour_written = cw_reg;
    assign status.pen            = pen_reg;

`ifndef SYNTHESIS
    a_mon_in_hblank: assert property (@(posedge aclk) disable iff (!aresetn)
        mon_reg |-> hs_reg)
        else $error("monitor sync active outside hblank");
    a_mon_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mon_reg) |-> $past(bcnt_reg) == BCNT_SYNC_ON)
        else $error("monitor sync started at wrong blank count");
`endif

endmodule

[rtl/core/gate_array_palette_sync_control.sv]
// Top level of the gate array palette and sync control block.
//
//  channel | dir | handshake           | payload
//  s_      | in  | s_tvalid / s_tready | s_tuser action, s_tdata data, level, timer_out
//  m_      | out | m_tvalid / m_tready | m_tdata pen, colour, flags, mode, sync, blanking
//
// One request per cycle sustained while m_tready holds high; a result passes through
// the registered read of the palette memory and then the output register.
// Reset: synchronous, active low; palette entries read as zero until written.
// A stalled output holds one result and one more request is taken into the
// memory read stage before s_tready drops.
module gate_array_palette_sync_control
    import gapsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [7:0] data, [8] level, [9] timer_out
    input  logic [1:0]  s_tuser,  // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // [4:0] pen_index, [9:5] pen_colour, [10] colour_written,
                                  // [16:11] mf_value, [18:17] line_mode, [19] upper_rom_on,
                                  // [20] lower_rom_on, [21] irq, [22] monitor_hsync,
                                  // [23] hblank, [24] vblank
);

    gapsc_mem_req_t      mem_req;
    gapsc_status_t       status;
    logic [COLOUR_W-1:0] rd_colour;

    logic             s2_valid_reg, s2_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;
    logic             accept;
    logic             s2_adv;

    assign s2_adv   = s2_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s2_valid_reg || s2_adv;
    assign accept   = s_tvalid && s_tready;

    gapsc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .action    (s_tuser),
        .data      (s_tdata[7:0]),
        .level     (s_tdata[8]),
        .timer_out (s_tdata[9]),
        .mem_req   (mem_req),
        .status    (status)
    );

    gapsc_pal_ram u_pal_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (rd_colour)
    );

    always_comb begin
        s2_valid_next  = accept ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_reg);
        out_valid_next = s2_adv ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        out_data_next  = {status.vblank, status.hblank, status.mon_sync, status.irq,
                          !status.mf[2], !status.mf[3], status.line_mode, status.mf,
                          status.colour_written, rd_colour, status.pen};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(32-OUT_W){1'b0}}, out_data_reg};

`ifndef SYNTHESIS
    a_out_from_s2: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(s2_valid_reg))
        else $error("result presented without a pending request");
`endif

endmodule

[tb/sv/gate_array_palette_sync_control_checker.sv]
// Checker for the gate array palette and sync control block: predicts and compares results.
`timescale 1ns / 1ps
module gate_array_palette_sync_control_checker
    import gapsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          mismatches,
    output int          outstanding
);

    // same order as m_tdata[24:0], msb first
    typedef struct packed {
        logic                vblank;
        logic                hblank;
        logic                mon_sync;
        logic                irq;
        logic                lower_rom;
        logic                upper_rom;
        logic [MODE_W-1:0]   mode;
        logic [MF_W-1:0]     mf;
        logic                wrote;
        logic [COLOUR_W-1:0] colour;
        logic [PEN_W-1:0]    pen;
    } gate_status_t;

    logic [COLOUR_W-1:0] pal [PEN_COUNT];
    logic [PEN_W-1:0]    sel_pen;
    logic [MF_W-1:0]     mf_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic                irq_reg;
    logic                hs_on;
    logic [BCNT_W-1:0]   bcnt;
    logic                mon_reg;
    logic                vs_on;

    gate_status_t status_q[$];
    int           fails = 0;

    function automatic string show(gate_status_t s);
        return {$sformatf("pen=%0d colour=%0d wr=%0b mf=%02h mode=%0d ",
                          s.pen, s.colour, s.wrote, s.mf, s.mode),
                $sformatf("urom=%0b lrom=%0b irq=%0b msync=%0b hbl=%0b vbl=%0b",
                          s.upper_rom, s.lower_rom, s.irq, s.mon_sync, s.hblank,
                          s.vblank)};
    endfunction

    // applies one request to the shadow state and returns the status it leaves
    task automatic apply_event(input logic [1:0] act, input logic [7:0] d, input logic lvl,
                               input logic tmr, output gate_status_t st);
        logic wrote;
        wrote = 1'b0;
        case (act)
            ACT_WRITE: begin
                case (d[7:6])
                    WR_PEN:    sel_pen = d[4] ? BORDER_PEN : {1'b0, d[3:0]};
                    WR_COLOUR: begin
                        pal[sel_pen] = d[4:0];
                        wrote = 1'b1;
                    end
                    WR_MF: begin
                        mf_reg = d[5:0];
                        if (d[4]) irq_reg = 1'b0;
                    end
                    default: ;
                endcase
            end
            ACT_HSYNC: begin
                if (lvl) begin
                    hs_on    = 1'b1;
                    bcnt     = '0;
                    mode_reg = mf_reg[1:0];
                end else begin
                    hs_on   = 1'b0;
                    mon_reg = 1'b0;
                end
                irq_reg = tmr;
            end
            ACT_VSYNC: begin
                if (lvl != vs_on) begin
                    vs_on = lvl;
                    if (lvl) irq_reg = tmr;
                end
            end
            default: begin
                if (hs_on) begin
                    if (bcnt == BCNT_SYNC_ON) mon_reg = 1'b1;
                    else if (bcnt == BCNT_SYNC_OFF) mon_reg = 1'b0;
                    if (bcnt < BCNT_MAX) bcnt = bcnt + 1'b1;
                end
            end
        endcase
        st.pen       = sel_pen;
        st.colour    = pal[sel_pen];
        st.wrote     = wrote;
        st.mf        = mf_reg;
        st.mode      = mode_reg;
        st.upper_rom = ~mf_reg[3];
        st.lower_rom = ~mf_reg[2];
        st.irq       = irq_reg;
        st.mon_sync  = mon_reg;
        st.hblank    = hs_on;
        st.vblank    = vs_on;
    endtask

    always @(posedge aclk) begin : watch
        gate_status_t got;
        gate_status_t want;
        int i;
        if (!aresetn) begin
            for (i = 0; i < PEN_COUNT; i++) pal[i] = '0;
            sel_pen  = '0;
            mf_reg   = '0;
            mode_reg = '0;
            irq_reg  = 1'b0;
            hs_on    = 1'b0;
            bcnt     = '0;
            mon_reg  = 1'b0;
            vs_on    = 1'b0;
            status_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = gate_status_t'(m_tdata[24:0]);
                if (status_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result: %s", show(got));
                end else begin
                    want = status_q.pop_front();
                    if (got.pen !== want.pen || got.colour !== want.colour ||
                        got.wrote !== want.wrote || got.mf !== want.mf ||
                        got.mode !== want.mode || got.upper_rom !== want.upper_rom ||
                        got.lower_rom !== want.lower_rom || got.irq !== want.irq ||
                        got.mon_sync !== want.mon_sync || got.hblank !== want.hblank ||
                        got.vblank !== want.vblank) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch at %0t\n  exp: %s\n  got: %s",
                                     $realtime, show(want), show(got));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                apply_event(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9], want);
                status_q.push_back(want);
            end
        end
        mismatches  <= fails;
        outstanding <= status_q.size();
    end

endmodule

[tb/sv/gate_array_palette_sync_control_tb.sv]
// Testbench top for the gate array palette and sync control block: stimulus and verdict.
`timescale 1ns / 1ps
module gate_array_palette_sync_control_tb
    import gapsc_pkg::*;
();

    localparam int RANDOM_ITEMS = 1650;
    localparam int QUIET_TAIL   = 150;
    localparam int CYCLE_LIMIT  = 200000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = ACT_WRITE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    int   mismatches;
    int   outstanding;
    int   sent      = 0;
    int   cycles    = 0;
    int   stall_left = 0;
    logic quiet     = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    gate_array_palette_sync_control dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    gate_array_palette_sync_control_checker status_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result-side backpressure in short bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send(input logic [1:0] act, input logic [7:0] d, input logic lvl,
                        input logic tmr);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'd0, tmr, lvl, d};
        do @(posedge aclk); while (!s_tready);
        sent++;
        if (sent >= RANDOM_ITEMS - QUIET_TAIL) quiet <= 1'b1;
    endtask

    task automatic write_byte(input logic [7:0] d);
        logic [31:0] r;
        r = $urandom;
        send(ACT_WRITE, d, r[0], r[1]);
    endtask

    task automatic sync_level(input logic [1:0] act, input logic lvl, input logic tmr);
        logic [31:0] r;
        r = $urandom;
        send(act, r[7:0], lvl, tmr);
    endtask

    task automatic tick();
        logic [31:0] r;
        r = $urandom;
        send(ACT_TICK, r[7:0], r[8], r[9]);
    endtask

    // mostly pen, colour and multifunction writes, now and then an ignored one
    task automatic random_write();
        logic [31:0] r;
        r = $urandom;
        if (r[31:29] == 3'd0) write_byte(r[7:0]);
        else write_byte({$urandom_range(0, 2) == 0 ? WR_PEN :
                         ($urandom_range(0, 1) == 0 ? WR_COLOUR : WR_MF), r[5:0]});
    endtask

    initial begin : stimulus
        logic [31:0] r;
        int          n;
        int          k;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        sent = 0;
        write_byte(8'h0F);
        write_byte(8'h5F);
        write_byte(8'h3F);
        write_byte(8'h55);
        write_byte(8'h00);
        write_byte(8'h40);
        write_byte(8'hC0);
        write_byte(8'hFF);
        write_byte(8'hBF);
        write_byte(8'h83);
        sync_level(ACT_HSYNC, 1'b1, 1'b1);
        repeat (8) tick();
        sync_level(ACT_HSYNC, 1'b1, 1'b0);
        write_byte(8'h8C);
        sync_level(ACT_HSYNC, 1'b0, 1'b1);
        sync_level(ACT_HSYNC, 1'b0, 1'b0);
        tick();
        sync_level(ACT_VSYNC, 1'b1, 1'b1);
        sync_level(ACT_VSYNC, 1'b1, 1'b0);
        sync_level(ACT_VSYNC, 1'b0, 1'b1);
        write_byte(8'h90);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 6) begin
                // one scan line: hsync high, ticks with writes and vsync events mixed in, usually hsync low
                sync_level(ACT_HSYNC, 1'b1, 1'($urandom_range(0, 1)));
                n = $urandom_range(0, 10);
                for (k = 0; k < n; k++) begin
                    r = $urandom_range(0, 9);
                    if (r < 6) tick();
                    else if (r < 9) random_write();
                    else sync_level(ACT_VSYNC, 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)));
                end
                if ($urandom_range(0, 7) != 0)
                    sync_level(ACT_HSYNC, 1'b0, 1'($urandom_range(0, 1)));
            end else begin
                r = $urandom;
                send(r[1:0], r[9:2], r[10], r[11]);
            end
        end

        s_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
